// ===== hw/rtl/in_position_dwell_detector_defines.svh =====
// ----------------------------------------------------------------------------
// In-position dwell detector: assertion macros
// Concurrent check macros, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef IN_POSITION_DWELL_DETECTOR_DEFINES_SVH
`define IN_POSITION_DWELL_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// Check outside reset.
`define IPD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check at every edge, reset included.
`define IPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define IPD_ASSERT(lbl, clk, rst, prop, msg)
`define IPD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/ipd_pkg.sv =====
// ----------------------------------------------------------------------------
// ipd_pkg
// Types, codes and constants shared by the in-position dwell detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ipd_pkg;

   localparam int unsigned COUNT_WIDTH_DEFAULT   = 16;
   localparam int unsigned FRACTION_BITS_DEFAULT = 8;

   localparam int unsigned TOL_W   = 23;
   localparam int unsigned DWELL_W = 16;
   localparam int unsigned ERR_W   = 32;
   localparam int unsigned SPEED_W = 16;
   localparam int unsigned MAG_W   = ERR_W + 1;
   localparam int unsigned STALL_W = 5;

   localparam logic [STALL_W-1:0] STALL_TICKS = 5'd20;
   localparam int unsigned STALL_Y_UNITS = 50;
   localparam int unsigned HEADING_UNITS = 1;

   // motion modes
   localparam logic [2:0] MODE_FULL   = 3'd0;
   localparam logic [2:0] MODE_STALL  = 3'd1;
   localparam logic [2:0] MODE_Y_HEAD = 3'd2;
   localparam logic [2:0] MODE_X_HEAD = 3'd3;
   localparam logic [2:0] MODE_HEAD   = 3'd4;

   // register indexes
   localparam logic [2:0] REG_MOTION_MODE      = 3'd0;
   localparam logic [2:0] REG_TOLERANCE_SELECT = 3'd1;
   localparam logic [2:0] REG_WIDE_TOLERANCE   = 3'd2;
   localparam logic [2:0] REG_NARROW_TOLERANCE = 3'd3;
   localparam logic [2:0] REG_SHORT_DWELL      = 3'd4;
   localparam logic [2:0] REG_LONG_DWELL       = 3'd5;

   localparam logic [TOL_W-1:0]   WIDE_TOL_RESET   = 23'd5120;
   localparam logic [TOL_W-1:0]   NARROW_TOL_RESET = 23'd1280;
   localparam logic [DWELL_W-1:0] SHORT_DWELL_RESET = 16'd10;
   localparam logic [DWELL_W-1:0] LONG_DWELL_RESET  = 16'd30;

   typedef struct packed {
      logic [2:0]         motion_mode;
      logic               tolerance_select;
      logic [TOL_W-1:0]   wide_tolerance;
      logic [TOL_W-1:0]   narrow_tolerance;
      logic [DWELL_W-1:0] short_dwell;
      logic [DWELL_W-1:0] long_dwell;
   } cfg_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] speed_y;
      logic signed [ERR_W-1:0]   error_heading;
      logic signed [ERR_W-1:0]   error_y;
      logic signed [ERR_W-1:0]   error_x;
   } item_type;

   typedef struct packed {
      logic zero_speed_request;
      logic stall_latched;
      logic arrived;
   } result_type;

   // exact magnitude, the most negative value included
   function automatic logic [MAG_W-1:0] magnitude(input logic [ERR_W-1:0] v);
      logic [MAG_W-1:0] ext;
      ext = {v[ERR_W-1], v};
      return v[ERR_W-1] ? (MAG_W'(0) - ext) : ext;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ipd_core.sv =====
// ----------------------------------------------------------------------------
// ipd_core
// Tolerance checks, dwell and stall counters for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

`include "in_position_dwell_detector_defines.svh"

module ipd_core #(
   parameter int unsigned COUNT_WIDTH   = ipd_pkg::COUNT_WIDTH_DEFAULT,
   parameter int unsigned FRACTION_BITS = ipd_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  advance,
   input  ipd_pkg::cfg_type     cfg,
   input  ipd_pkg::item_type    item,
   output ipd_pkg::result_type  result
);
   import ipd_pkg::*;

   localparam int unsigned CMP_W = (COUNT_WIDTH > DWELL_W) ? COUNT_WIDTH : DWELL_W;
   localparam logic [MAG_W-1:0] HEAD_TOL  = MAG_W'(HEADING_UNITS) << FRACTION_BITS;
   localparam logic [MAG_W-1:0] STALL_TOL = MAG_W'(STALL_Y_UNITS) << FRACTION_BITS;

   logic [COUNT_WIDTH-1:0] dwell_count_ff, dwell_count_in;
   logic [STALL_W-1:0]     stall_count_ff, stall_count_in;
   logic                   stall_flag_ff, stall_flag_in;

   logic [MAG_W-1:0]       ax, ay, ah, tol;
   logic [DWELL_W-1:0]     target;
   logic                   x_ok, y_ok, h_ok, stall_cond, flag_mid, in_tol, tracked;
   logic [STALL_W-1:0]     stall_next;
   logic [COUNT_WIDTH-1:0] dwell_inc;
   logic                   dwell_met;

   always_comb begin
      tol    = MAG_W'(cfg.tolerance_select ? cfg.narrow_tolerance : cfg.wide_tolerance);
      target = cfg.tolerance_select ? cfg.long_dwell : cfg.short_dwell;
      ax     = magnitude(item.error_x);
      ay     = magnitude(item.error_y);
      ah     = magnitude(item.error_heading);
      x_ok   = ax <= tol;
      y_ok   = ay <= tol;
      h_ok   = ah <= HEAD_TOL;

      stall_cond = (item.speed_y == '0) && (ay <= STALL_TOL);
      if (!stall_cond) begin
         stall_next = '0;
      end else if (stall_count_ff < STALL_TICKS) begin
         stall_next = stall_count_ff + STALL_W'(1);
      end else begin
         stall_next = stall_count_ff;
      end
      flag_mid = stall_flag_ff | (stall_cond && (stall_next >= STALL_TICKS));

      tracked = 1'b1;
      unique case (cfg.motion_mode)
         MODE_FULL:   in_tol = x_ok && y_ok && h_ok;
         MODE_STALL:  in_tol = x_ok && flag_mid;
         MODE_Y_HEAD: in_tol = y_ok && h_ok;
         MODE_X_HEAD: in_tol = x_ok && h_ok;
         MODE_HEAD:   in_tol = h_ok;
         default: begin
            in_tol  = 1'b0;
            tracked = 1'b0;
         end
      endcase

      // saturate at all ones
      dwell_inc = (&dwell_count_ff) ? dwell_count_ff : dwell_count_ff + COUNT_WIDTH'(1);
      dwell_met = in_tol && (CMP_W'(dwell_inc) >= CMP_W'(target));

      dwell_count_in = dwell_count_ff;
      stall_count_in = stall_count_ff;
      stall_flag_in  = stall_flag_ff;
      result.arrived            = 1'b1;
      result.zero_speed_request = 1'b0;

      if (tracked) begin
         dwell_count_in = (in_tol && !dwell_met) ? dwell_inc : '0;
         result.arrived = dwell_met;
         if (cfg.motion_mode == MODE_STALL) begin
            stall_count_in            = stall_next;
            stall_flag_in             = flag_mid && !dwell_met;
            result.zero_speed_request = in_tol;
         end
      end
      result.stall_latched = stall_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_count_ff <= '0;
         stall_count_ff <= '0;
         stall_flag_ff  <= 1'b0;
      end else if (advance) begin
         dwell_count_ff <= dwell_count_in;
         stall_count_ff <= stall_count_in;
         stall_flag_ff  <= stall_flag_in;
      end
   end

   `IPD_ASSERT_ALWAYS(a_reset_clear, clock,
      reset |=> (stall_count_ff == '0 && !stall_flag_ff && dwell_count_ff == '0),
      "state not cleared by reset")
   `IPD_ASSERT(a_stall_count_bound, clock, reset,
      stall_count_ff <= STALL_TICKS, "stall count beyond limit")
   `IPD_ASSERT(a_stall_state_hold, clock, reset,
      (!advance || cfg.motion_mode != MODE_STALL) |=>
         ($stable(stall_flag_ff) && $stable(stall_count_ff)),
      "stall state moved outside stall mode")
   `IPD_ASSERT(a_dwell_clear, clock, reset,
      (advance && tracked && (!in_tol || dwell_met)) |=> (dwell_count_ff == '0),
      "dwell count not cleared")

endmodule

`default_nettype wire

// ===== hw/rtl/in_position_dwell_detector.sv =====
// ----------------------------------------------------------------------------
// in_position_dwell_detector
// Reports arrival once the axes picked by the motion mode stay in tolerance
// for the selected dwell, with a latched stall detector for one mode.
// ----------------------------------------------------------------------------
//
//  channel | ports                      | beat contents
//  --------+----------------------------+--------------------------------------
//  req     | req_tvalid/tready/tdata    | error_x, error_y, error_heading,speed_y
//  rsp     | rsp_tvalid/tready/tdata    | arrived, stall_latched, zero_speed_req
//  csr     | csr_we/index/wdata         | register write, no read-back
//
//  One beat in and one beat out per cycle when rsp is not stalled; rsp_tvalid
//  rises once the accepted req beat has passed the input register and then
//  the result register, fed by the single-pass evaluation and counter update.
//  A stalled result register holds its beat; the input register still takes
//  one more beat, then req_tready drops until rsp drains.
//  Synchronous reset clears the counters, the stall flag, both valid bits
//  and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module in_position_dwell_detector #(
   parameter int unsigned COUNT_WIDTH   = ipd_pkg::COUNT_WIDTH_DEFAULT,
   parameter int unsigned FRACTION_BITS = ipd_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire          clock,
   input  wire          reset,
   // request stream
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [111:0] req_tdata,   // error_x, error_y, error_heading, speed_y
   // result stream
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [7:0]   rsp_tdata,   // arrived, stall_latched, zero_speed_request, pad
   // register writes
   input  wire          csr_we,
   input  wire  [2:0]   csr_index,
   input  wire  [22:0]  csr_wdata
);
   import ipd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   item_type   item_ff;
   logic       in_valid_ff;
   result_type rsp_ff, core_result;
   logic       rsp_valid_ff;
   logic       advance;

   // Move the held beat forward when the result register is free or draining.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Decode register writes; drop indexes beyond the list.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MOTION_MODE:      cfg_in.motion_mode      = csr_wdata[2:0];
            REG_TOLERANCE_SELECT: cfg_in.tolerance_select = csr_wdata[0];
            REG_WIDE_TOLERANCE:   cfg_in.wide_tolerance   = csr_wdata[TOL_W-1:0];
            REG_NARROW_TOLERANCE: cfg_in.narrow_tolerance = csr_wdata[TOL_W-1:0];
            REG_SHORT_DWELL:      cfg_in.short_dwell      = csr_wdata[DWELL_W-1:0];
            REG_LONG_DWELL:       cfg_in.long_dwell       = csr_wdata[DWELL_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motion_mode      <= MODE_FULL;
         cfg_ff.tolerance_select <= 1'b1;
         cfg_ff.wide_tolerance   <= WIDE_TOL_RESET;
         cfg_ff.narrow_tolerance <= NARROW_TOL_RESET;
         cfg_ff.short_dwell      <= SHORT_DWELL_RESET;
         cfg_ff.long_dwell       <= LONG_DWELL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register: capture the beat, hold it until it advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_type'(req_tdata);
      end
   end

   ipd_core #(
      .COUNT_WIDTH   (COUNT_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg_ff),
      .item    (item_ff),
      .result  (core_result)
   );

   // Result register: load on advance, clear valid once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff};

endmodule

`default_nettype wire
